// File: hw/rtl/egbw_pkg.sv
// ----------------------------------------------------------------------------
// egbw_pkg
// Shared types and constants of the Exp-Golomb bit writer.
// ----------------------------------------------------------------------------
`default_nettype none

package egbw_pkg;

    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned RAW_MAX     = 32;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Largest legal mapped code value is one below this limit.
    localparam logic [32:0] EG_LIMIT = 33'h0_7fff_ffff;

    typedef enum logic [2:0] {
        KIND_RAW   = 3'd0,
        KIND_UEG   = 3'd1,
        KIND_SEG   = 3'd2,
        KIND_ALIGN = 3'd3,
        KIND_RESET = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_COUNT = 2'd1,
        STATUS_BAD_RANGE = 2'd2
    } status_t;

    // Work handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_BITS  = 2'd0,
        OP_ALIGN = 2'd1,
        OP_CLEAR = 2'd2,
        OP_ERR   = 2'd3
    } op_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [5:0]  bit_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] code;    // bits to append, right-aligned
        logic [5:0]  nbits;   // 1..61 for OP_BITS
        status_t     status;  // for OP_ERR
    } queue_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/egbw_fifo.sv
// ----------------------------------------------------------------------------
// egbw_fifo
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module egbw_fifo
    import egbw_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  queue_entry_t      push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              rd_valid,
    output queue_entry_t      rd_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    queue_entry_t        mem [DEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/egbw_front.sv
// ----------------------------------------------------------------------------
// egbw_front
// Accept items, map Exp-Golomb values, check ranges and size the codes.
// ----------------------------------------------------------------------------
`default_nettype none

module egbw_front
    import egbw_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  in_item_t     s_data,
    output logic         q_push,
    output queue_entry_t q_data,
    input  wire logic    q_full
);

    logic        valid_reg;
    logic [2:0]  kind_reg;
    logic [31:0] value_reg;
    logic [5:0]  count_reg;
    logic [32:0] mapped_reg;

    logic [32:0] mapped_next;
    logic [31:0] neg_value;
    logic [30:0] m_code;
    logic [4:0]  m_len;
    logic        drop;
    logic        done;
    logic        accept;

    // Signed mapping: positive v to 2v-1, otherwise -2v.
    always_comb begin
        neg_value = 32'd0 - s_data.value;
        if (s_data.kind == KIND_SEG) begin
            if (s_data.value != 32'd0 && !s_data.value[31]) begin
                mapped_next = {s_data.value, 1'b0} - 33'd1;
            end else begin
                mapped_next = {neg_value, 1'b0};
            end
        end else begin
            mapped_next = {1'b0, s_data.value};
        end
    end

    // Code word and its bit length.
    always_comb begin
        m_code = mapped_reg[30:0] + 31'd1;
        m_len  = '0;
        for (int i = 0; i < 31; i++) begin
            if (m_code[i]) begin
                m_len = 5'(i + 1);
            end
        end
    end

    always_comb begin
        drop          = 1'b0;
        q_data.op     = OP_BITS;
        q_data.code   = value_reg;
        q_data.nbits  = count_reg;
        q_data.status = STATUS_OK;
        unique case (kind_reg)
            KIND_RAW: begin
                if (count_reg > 6'(RAW_MAX)) begin
                    q_data.op     = OP_ERR;
                    q_data.status = STATUS_BAD_COUNT;
                end else if (count_reg == 6'd0) begin
                    drop = 1'b1;
                end
            end
            KIND_UEG, KIND_SEG: begin
                if (mapped_reg >= EG_LIMIT) begin
                    q_data.op     = OP_ERR;
                    q_data.status = STATUS_BAD_RANGE;
                end else begin
                    q_data.code  = {1'b0, m_code};
                    q_data.nbits = {m_len, 1'b0} - 6'd1;
                end
            end
            KIND_ALIGN: q_data.op = OP_ALIGN;
            KIND_RESET: q_data.op = OP_CLEAR;
            default:    drop = 1'b1;
        endcase
    end

    assign done    = valid_reg && (drop || !q_full);
    assign q_push  = valid_reg && !drop && !q_full;
    assign s_ready = !valid_reg || done;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (done) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg   <= s_data.kind;
            value_reg  <= s_data.value;
            count_reg  <= s_data.bit_count;
            mapped_reg <= mapped_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/egbw_back.sv
// ----------------------------------------------------------------------------
// egbw_back
// Pack queued codes MSB first and stream out at most one byte per cycle, stalling while m_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module egbw_back
    import egbw_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    q_valid,
    input  queue_entry_t q_data,
    output logic         q_pop,
    output logic         m_valid,
    input  wire logic    m_ready,
    output out_item_t    m_data
);

    logic        busy_reg,  busy_next;
    logic [63:0] data_reg,  data_next;   // left-aligned bits still to send
    logic [5:0]  rem_reg,   rem_next;
    logic [6:0]  pbits_reg, pbits_next;
    logic [2:0]  pcnt_reg,  pcnt_next;
    logic        mval_reg,  mval_next;
    out_item_t   mdat_reg,  mdat_next;

    logic [3:0]  need;
    logic [14:0] window;
    logic [14:0] byte_win;
    logic [14:0] tail_win;
    logic        out_free;
    logic        emit;
    logic        advance;
    logic        finishing;
    logic        slot_free;

    assign need     = 4'(BYTE_BITS) - {1'b0, pcnt_reg};
    assign window   = {pbits_reg, data_reg[63:56]};
    assign byte_win = window >> pcnt_reg;
    assign tail_win = window >> (4'(BYTE_BITS) - {1'b0, rem_reg[2:0]});
    assign out_free = !mval_reg || m_ready;
    assign emit     = busy_reg && (rem_reg >= {2'b0, need});
    assign advance  = busy_reg && (!emit || out_free);
    assign finishing = advance && (rem_reg <= {2'b0, need});
    assign slot_free = !busy_reg || finishing;

    always_comb begin
        busy_next  = busy_reg;
        data_next  = data_reg;
        rem_next   = rem_reg;
        pbits_next = pbits_reg;
        pcnt_next  = pcnt_reg;
        mval_next  = mval_reg && !m_ready;
        mdat_next  = mdat_reg;
        q_pop      = 1'b0;

        if (advance) begin
            if (emit) begin
                mdat_next.out_byte = byte_win[7:0];
                // Final byte of the item when no whole byte remains after it.
                mdat_next.last     = (rem_reg < ({2'b0, need} + 6'd8));
                mdat_next.status   = STATUS_OK;
                mval_next  = 1'b1;
                pbits_next = '0;
                pcnt_next  = '0;
                data_next  = data_reg << need;
                rem_next   = rem_reg - {2'b0, need};
                if (finishing) begin
                    busy_next = 1'b0;
                end
            end else begin
                pbits_next = tail_win[6:0];
                pcnt_next  = pcnt_reg + rem_reg[2:0];
                busy_next  = 1'b0;
            end
        end

        if (q_valid && slot_free) begin
            unique case (q_data.op)
                OP_BITS: begin
                    q_pop     = 1'b1;
                    busy_next = 1'b1;
                    data_next = {32'd0, q_data.code} << (7'd64 - {1'b0, q_data.nbits});
                    rem_next  = q_data.nbits;
                end
                OP_ALIGN: begin
                    q_pop = 1'b1;
                    if (pcnt_next != 3'd0) begin
                        busy_next = 1'b1;
                        data_next = '0;
                        rem_next  = 6'(BYTE_BITS) - {3'b0, pcnt_next};
                    end
                end
                OP_CLEAR: begin
                    q_pop      = 1'b1;
                    pbits_next = '0;
                    pcnt_next  = '0;
                end
                OP_ERR: begin
                    if (!busy_reg && out_free) begin
                        q_pop              = 1'b1;
                        mdat_next.out_byte = '0;
                        mdat_next.last     = 1'b1;
                        mdat_next.status   = q_data.status;
                        mval_next          = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            rem_reg   <= '0;
            pbits_reg <= '0;
            pcnt_reg  <= '0;
            mval_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            rem_reg   <= rem_next;
            pbits_reg <= pbits_next;
            pcnt_reg  <= pcnt_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        mdat_reg <= mdat_next;
    end

    assign m_valid = mval_reg;
    assign m_data  = mdat_reg;

endmodule

`default_nettype wire

// File: hw/rtl/exp_golomb_bit_writer.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer
// MSB-first bit packer for raw fields and Exp-Golomb codes, byte stream out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one operation per beat (raw bits, unsigned or signed
//   Exp-Golomb, byte align, drop pending bits). m_* channel: one completed
//   byte per beat, first appended bit in bit 7; last marks the final beat an
//   operation causes. A count above 32 or an out-of-range code gives a single
//   status beat with byte 0 and leaves the pending bits untouched.
//   Path: an input beat is registered in the front end, then in the queue;
//   a code then loads the back end's bit register before its first byte is
//   registered at the output, while a status beat goes there straight.
//   Throughput: the back end sends one byte per cycle while m_ready is high,
//   pausing while it parks an operation's leftover bits. The front end takes
//   one beat per cycle into a short operation queue while it has room, so
//   input keeps flowing while the byte drain works or m_ready is low.
//   Reset (aresetn low, synchronous) empties the queue, clears pending
//   bits and drops any result not yet taken.
//   When the receiver stalls, the output register holds its beat; the queue
//   then fills and s_ready falls until bytes drain again.
// ----------------------------------------------------------------------------
`default_nettype none

module exp_golomb_bit_writer
    import egbw_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_data
);

    // Classified operations travel front -> queue -> back.
    logic         push;
    logic         full;
    logic         pop;
    logic         rd_valid;
    queue_entry_t push_data;
    queue_entry_t rd_data;

    // Front: accept beats, map signed values, check ranges, size the code.
    egbw_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (push),
        .q_data  (push_data),
        .q_full  (full)
    );

    // Queue: decouple classification from the byte drain.
    egbw_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .rd_valid  (rd_valid),
        .rd_data   (rd_data)
    );

    // Back: hold pending bits, advance one byte per cycle while m_ready allows, drive the output.
    egbw_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (rd_valid),
        .q_data  (rd_data),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Exp-Golomb bit writer: directed corner beats,
// then random operations, with a bit-level packer model predicting every
// output byte and status beat under random gaps and back-pressure.
// ----------------------------------------------------------------------------

module tb_top;
    import egbw_pkg::*;

    // Kind codes the block must ignore.
    localparam logic [2:0] KIND_SPARE5 = 3'd5;
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam int RANDOM_BEATS = 480;
    localparam int QUIET_TAIL   = 60;     // last beats run with no gaps or stalls
    localparam int DRAIN_LIMIT  = 20000;  // cycles allowed to drain at the end
    localparam int SETTLE_CYCLES = 40;    // watch for stray beats after drain

    // ------------------------------------------------------------------------
    // Byte stream predictor: holds the partial byte, expands each operation
    // to bits MSB first and queues every byte it completes.
    // ------------------------------------------------------------------------
    class byte_stream_board;
        logic [6:0] held_bits;
        logic [2:0] held_cnt;
        out_item_t  expected_q[$];
        int         fails;

        function new();
            held_bits = '0;
            held_cnt  = '0;
            fails     = 0;
        endfunction

        function void shift_in_bit(logic b);
            logic [7:0] acc;
            acc = {held_bits, b};
            if (held_cnt == 3'd7) begin
                expected_q.push_back('{out_byte: acc, last: 1'b0, status: STATUS_OK});
                held_bits = '0;
                held_cnt  = '0;
            end else begin
                held_bits = acc[6:0];
                held_cnt  = held_cnt + 3'd1;
            end
        endfunction

        function void shift_in_code(logic [63:0] code, int nbits);
            for (int i = nbits - 1; i >= 0; i--)
                shift_in_bit(code[i]);
        endfunction

        // Expand one accepted input beat into its expected output beats.
        function void note_op(in_item_t op);
            int         first;
            int         len;
            logic [33:0] mapped;
            logic [31:0] neg;
            logic [31:0] code_num;
            first = expected_q.size();
            case (op.kind)
                KIND_RAW: begin
                    if (op.bit_count > RAW_MAX)
                        expected_q.push_back('{out_byte: 8'h00, last: 1'b1,
                                               status: STATUS_BAD_COUNT});
                    else
                        shift_in_code({32'h0, op.value}, op.bit_count);
                end
                KIND_UEG, KIND_SEG: begin
                    if (op.kind == KIND_UEG) begin
                        mapped = {2'b00, op.value};
                    end else if (op.value != 32'h0 && !op.value[31]) begin
                        mapped = {1'b0, op.value, 1'b0} - 34'd1;
                    end else begin
                        // non-positive: twice the magnitude, 2^32 for the most negative
                        neg    = -op.value;
                        mapped = {1'b0, neg, 1'b0};
                    end
                    if (mapped >= {1'b0, EG_LIMIT}) begin
                        expected_q.push_back('{out_byte: 8'h00, last: 1'b1,
                                               status: STATUS_BAD_RANGE});
                    end else begin
                        code_num = mapped[31:0] + 32'd1;
                        len = 0;
                        while (len < 32 && (code_num >> len) != 0)
                            len++;
                        shift_in_code({32'h0, code_num}, 2 * len - 1);
                    end
                end
                KIND_ALIGN: begin
                    if (held_cnt != 0)
                        shift_in_code(64'h0, BYTE_BITS - held_cnt);
                end
                KIND_RESET: begin
                    held_bits = '0;
                    held_cnt  = '0;
                end
                default: ;
            endcase
            if (expected_q.size() > first)
                expected_q[$].last = 1'b1;
        endfunction

        function void check_byte(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected beat: out_byte %h last %b status %0d",
                       got.out_byte, got.last, got.status);
                fails++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, got.last);
                fails++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                fails++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    byte_stream_board sb = new();

    int  gap_pct   = 0;   // chance of an input gap before a beat
    int  stall_pct = 0;   // chance of starting an m_ready stall burst
    int  stall_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    exp_golomb_bit_writer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the edge, before any NBA lands.
    // Note the input beat first so its bytes are queued before they can show.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_op(s_data);
            if (m_valid && m_ready)
                sb.check_byte(m_data);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: hold m_ready low in bursts of random length, otherwise keep it
    // high. stall_pct of zero gives long stretches with no stalls at all.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(12, 1) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic in_item_t make_op(logic [2:0] kind, logic [31:0] value,
                                         logic [5:0] bit_count);
        in_item_t op;
        op.kind      = kind;
        op.value     = value;
        op.bit_count = bit_count;
        return op;
    endfunction

    // Spread values over all magnitudes, with a share right at the code limit.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom >> $urandom_range(31);
            2:       return $urandom_range(15);
            default: return EG_LIMIT[31:0] - $urandom_range(3);
        endcase
    endfunction

    // Mostly well-formed operations; a few bad counts, resets and spare kinds.
    function automatic in_item_t pick_op();
        in_item_t    op;
        int unsigned roll;
        roll         = $urandom_range(99);
        op.value     = pick_value();
        op.bit_count = 6'($urandom_range(63));
        if (roll < 35) begin
            op.kind      = KIND_RAW;
            op.bit_count = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 33))
                                                     : 6'($urandom_range(32));
        end else if (roll < 57) begin
            op.kind = KIND_UEG;
        end else if (roll < 80) begin
            op.kind = KIND_SEG;
            if ($urandom_range(1))
                op.value = -op.value;
        end else if (roll < 92) begin
            op.kind = KIND_ALIGN;
        end else if (roll < 97) begin
            op.kind = KIND_RESET;
        end else begin
            op.kind = 3'($urandom_range(KIND_SPARE7, KIND_SPARE5));
        end
        return op;
    endfunction

    // Present one beat and hold it until accepted. An optional gap drops
    // valid first; otherwise valid stays high straight into the next beat.
    task automatic send_op(in_item_t op);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        waited = 0;

        // Hold reset low from the start, then release it on an edge.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: field extremes, each operation, each error path.
        gap_pct   = 20;
        stall_pct = 20;
        send_op(make_op(KIND_RAW,   32'h0000_0000, 6'd0));    // nothing appended
        send_op(make_op(KIND_RAW,   32'hffff_ffff, 6'd32));   // four full bytes
        send_op(make_op(KIND_RAW,   32'hffff_ffff, 6'd33));   // count above limit
        send_op(make_op(KIND_RAW,   32'h0000_0000, 6'd63));
        send_op(make_op(KIND_RAW,   32'hffff_fff1, 6'd1));    // high bits ignored
        send_op(make_op(KIND_RAW,   32'hffff_ff55, 6'd7));    // completes a byte
        send_op(make_op(KIND_UEG,   32'h0000_0000, 6'd0));    // single '1'
        send_op(make_op(KIND_UEG,   32'h7fff_fffe, 6'd63));   // longest legal code
        send_op(make_op(KIND_UEG,   32'h7fff_ffff, 6'd0));    // at the limit
        send_op(make_op(KIND_UEG,   32'hffff_ffff, 6'd0));
        send_op(make_op(KIND_SEG,   32'h0000_0000, 6'd0));
        send_op(make_op(KIND_SEG,   32'h0000_0001, 6'd0));
        send_op(make_op(KIND_SEG,   32'hffff_ffff, 6'd0));    // minus one
        send_op(make_op(KIND_SEG,   32'h3fff_ffff, 6'd0));    // largest legal positive
        send_op(make_op(KIND_SEG,   32'h4000_0000, 6'd0));    // maps onto the limit
        send_op(make_op(KIND_SEG,   32'hc000_0001, 6'd0));    // largest legal negative
        send_op(make_op(KIND_SEG,   32'hc000_0000, 6'd0));
        send_op(make_op(KIND_SEG,   32'h8000_0000, 6'd0));    // most negative
        send_op(make_op(KIND_SEG,   32'h7fff_ffff, 6'd0));    // most positive
        send_op(make_op(KIND_RAW,   32'h0000_0005, 6'd3));
        send_op(make_op(KIND_ALIGN, 32'h0000_0000, 6'd0));    // pads six zeros
        send_op(make_op(KIND_ALIGN, 32'hffff_ffff, 6'd63));   // already aligned
        send_op(make_op(KIND_RAW,   32'h0000_0006, 6'd3));
        send_op(make_op(KIND_RESET, 32'h0000_0000, 6'd0));    // drop pending bits
        send_op(make_op(KIND_SPARE5, 32'hffff_ffff, 6'd32));
        send_op(make_op(KIND_SPARE6, 32'h1234_5678, 6'd8));
        send_op(make_op(KIND_SPARE7, 32'h0000_0001, 6'd1));

        // Random part: reshuffle gap and stall rates every 40 beats, then
        // run the tail flat out.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n >= RANDOM_BEATS - QUIET_TAIL) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (n % 40 == 0) begin
                case ($urandom_range(3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    2:       gap_pct = 40;
                    default: gap_pct = 70;
                endcase
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            end
            send_op(pick_op());
        end
        s_valid <= 1'b0;

        // Drain: wait for every queued byte, bounded.
        while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end

        if (sb.expected_q.size() != 0) begin
            $error("%0d expected beats never arrived", sb.expected_q.size());
            $display("Mismatches found");
            $finish;
        end else begin
            // Give stray beats from result-free operations time to show up.
            repeat (SETTLE_CYCLES) @(posedge aclk);
            if (sb.expected_q.size() != 0) begin
                $error("%0d expected beats left over", sb.expected_q.size());
                sb.fails++;
            end
            if (sb.fails == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
            $finish;
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
